/* design/tstq_pkg.sv */
// Shared types and constants for the time-sorted task queue.
package tstq_pkg;

    localparam int ID_BITS         = 4;
    localparam int CMD_BITS        = 2;
    localparam int FIELD_TIME_BITS = 32;
    localparam int DEF_TASK_COUNT  = 16;
    localparam int DEF_TIME_BITS   = 32;

    localparam logic [CMD_BITS-1:0] CMD_ADD     = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_REMOVE  = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_PERFORM = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_POP
    } t_state;

    typedef enum logic [1:0] {
        CM_HOLD,
        CM_DROP,
        CM_INSERT,
        CM_POP
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode         mode;
        logic [ID_BITS-1:0] key_id;
    } t_cell_ctl;

endpackage

/* design/tstq_cell.sv */
// One queue slot: holds an entry and trades it with its neighbors.
module tstq_cell #(
    parameter int TIME_BITS = tstq_pkg::DEF_TIME_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tstq_pkg::t_cell_ctl          i_ctl,
    input  logic [TIME_BITS-1:0]         i_key_time,
    input  logic                         i_pfx_match,
    input  logic                         i_left_ge,
    input  logic                         i_full,
    input  logic                         i_left_valid,
    input  logic [tstq_pkg::ID_BITS-1:0] i_left_id,
    input  logic [TIME_BITS-1:0]         i_left_time,
    input  logic                         i_right_valid,
    input  logic [tstq_pkg::ID_BITS-1:0] i_right_id,
    input  logic [TIME_BITS-1:0]         i_right_time,
    output logic                         o_valid,
    output logic [tstq_pkg::ID_BITS-1:0] o_id,
    output logic [TIME_BITS-1:0]         o_time,
    output logic                         o_match,
    output logic                         o_ge,
    output logic                         o_due
);

    logic                         r_valid, n_valid;
    logic [tstq_pkg::ID_BITS-1:0] r_id, n_id;
    logic [TIME_BITS-1:0]         r_time, n_time;

    assign o_valid = r_valid;
    assign o_id    = r_id;
    assign o_time  = r_time;
    assign o_match = r_valid && (r_id == i_ctl.key_id);
    assign o_ge    = !r_valid || (r_time >= i_key_time);
    assign o_due   = r_valid && (r_time <= i_key_time);

    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        n_time  = r_time;
        unique case (i_ctl.mode)
            tstq_pkg::CM_HOLD: begin
            end
            tstq_pkg::CM_DROP: begin
                if (i_pfx_match) begin
                    n_valid = i_right_valid;
                    n_id    = i_right_id;
                    n_time  = i_right_time;
                end
            end
            tstq_pkg::CM_INSERT: begin
                if (!i_full) begin
                    if (i_left_ge) begin
                        n_valid = i_left_valid;
                        n_id    = i_left_id;
                        n_time  = i_left_time;
                    end else if (o_ge) begin
                        n_valid = 1'b1;
                        n_id    = i_ctl.key_id;
                        n_time  = i_key_time;
                    end
                end
            end
            tstq_pkg::CM_POP: begin
                n_valid = i_right_valid;
                n_id    = i_right_id;
                n_time  = i_right_time;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_time <= n_time;
    end

endmodule

/* design/time_sorted_task_queue.sv */
// Top level of the time-sorted task queue: command decode, cell row and result port.
//
// Usage
//   A command transaction is taken at a rising edge where start is high and busy
//   is low. i_cmd selects add/reschedule, remove or perform; i_task_id names the
//   task, i_due_time carries its due time (add) or the current time (perform).
//   Only the low TIME_BITS bits of the time are used, compared unsigned.
//   Entries sit in a row of TASK_COUNT cells, front first, kept in due-time order.
//   Each cell trades its entry with a neighbor, so every command step is a
//   registered shift of the row.
// Timing
//   Remove: the matching cell and everything behind it shift forward.
//   Add: drop the old entry, then open a gap and insert; busy is high
//   for the insert step.
//   Perform: one due entry pops per cycle; busy is high while more due entries follow.
//   Results appear on o_expired_task/o_last with o_valid high for one cycle,
//   the first in the cycle after the command transaction, then one per cycle.
//   o_last marks the final result. A perform with nothing due gives no result.
// Reset
//   Synchronous, active low: the queue empties and no result is pending.
//   The receiver cannot stall; every o_valid cycle is a delivered transaction.
module time_sorted_task_queue #(
    parameter int TASK_COUNT = tstq_pkg::DEF_TASK_COUNT,
    parameter int TIME_BITS  = tstq_pkg::DEF_TIME_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [tstq_pkg::CMD_BITS-1:0]        i_cmd,
    input  logic [tstq_pkg::ID_BITS-1:0]         i_task_id,
    input  logic [tstq_pkg::FIELD_TIME_BITS-1:0] i_due_time,
    output logic                                 o_valid,
    output logic [tstq_pkg::ID_BITS-1:0]         o_expired_task,
    output logic                                 o_last
);

    tstq_pkg::t_state             r_state, n_state;
    logic [tstq_pkg::ID_BITS-1:0] r_key_id;
    logic [TIME_BITS-1:0]         r_key_time;
    logic                         r_strobe, n_strobe;
    logic [tstq_pkg::ID_BITS-1:0] r_task, n_task;
    logic                         r_last, n_last;

    tstq_pkg::t_cell_ctl          w_ctl;
    logic [TIME_BITS-1:0]         w_key_time;
    logic [TIME_BITS-1:0]         w_in_time;
    logic                         w_accept;
    logic                         w_full;

    logic [TASK_COUNT-1:0]        w_valid;
    logic [TASK_COUNT-1:0]        w_match;
    logic [TASK_COUNT-1:0]        w_pfx;
    logic [TASK_COUNT-1:0]        w_ge;
    logic [TASK_COUNT-1:0]        w_due;
    logic [tstq_pkg::ID_BITS-1:0] w_id   [TASK_COUNT];
    logic [TIME_BITS-1:0]         w_time [TASK_COUNT];

    // Narrow or zero-extend the time field to the compare width.
    generate
        if (TIME_BITS <= tstq_pkg::FIELD_TIME_BITS) begin : g_time_trunc
            assign w_in_time = i_due_time[TIME_BITS-1:0];
        end else begin : g_time_ext
            assign w_in_time = {{(TIME_BITS - tstq_pkg::FIELD_TIME_BITS){1'b0}}, i_due_time};
        end
    endgenerate

    assign busy     = (r_state != tstq_pkg::S_IDLE);
    assign w_accept = start && !busy;
    // Full after the drop step: the tail cell still holds an entry.
    assign w_full   = w_valid[TASK_COUNT-1];

    // Row of cells; each sees its left and right neighbor.
    genvar g;
    generate
        for (g = 0; g < TASK_COUNT; g++) begin : g_cell
            logic                         l_valid, r_valid_nb, l_ge;
            logic [tstq_pkg::ID_BITS-1:0] l_id, r_id_nb;
            logic [TIME_BITS-1:0]         l_time, r_time_nb;

            // Shift point of a drop: the match sits at or ahead of this cell.
            assign w_pfx[g] = |w_match[g:0];

            if (g == 0) begin : g_head
                assign l_valid = 1'b0;
                assign l_id    = '0;
                assign l_time  = '0;
                assign l_ge    = 1'b0;
            end else begin : g_body
                assign l_valid = w_valid[g-1];
                assign l_id    = w_id[g-1];
                assign l_time  = w_time[g-1];
                assign l_ge    = w_ge[g-1];
            end

            if (g == TASK_COUNT - 1) begin : g_tail
                assign r_valid_nb = 1'b0;
                assign r_id_nb    = '0;
                assign r_time_nb  = '0;
            end else begin : g_inner
                assign r_valid_nb = w_valid[g+1];
                assign r_id_nb    = w_id[g+1];
                assign r_time_nb  = w_time[g+1];
            end

            tstq_cell #(
                .TIME_BITS (TIME_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_key_time   (w_key_time),
                .i_pfx_match  (w_pfx[g]),
                .i_left_ge    (l_ge),
                .i_full       (w_full),
                .i_left_valid (l_valid),
                .i_left_id    (l_id),
                .i_left_time  (l_time),
                .i_right_valid(r_valid_nb),
                .i_right_id   (r_id_nb),
                .i_right_time (r_time_nb),
                .o_valid      (w_valid[g]),
                .o_id         (w_id[g]),
                .o_time       (w_time[g]),
                .o_match      (w_match[g]),
                .o_ge         (w_ge[g]),
                .o_due        (w_due[g])
            );
        end
    endgenerate

    // Sequencer: decode the command, drive the row, produce results.
    always_comb begin
        n_state      = r_state;
        w_ctl.mode   = tstq_pkg::CM_HOLD;
        w_ctl.key_id = r_key_id;
        w_key_time   = r_key_time;
        n_strobe     = 1'b0;
        n_task       = r_task;
        n_last       = r_last;
        unique case (r_state)
            tstq_pkg::S_IDLE: begin
                w_ctl.key_id = i_task_id;
                w_key_time   = w_in_time;
                if (w_accept) begin
                    unique case (i_cmd)
                        tstq_pkg::CMD_ADD: begin
                            // Drop any old entry first, insert next cycle.
                            w_ctl.mode = tstq_pkg::CM_DROP;
                            n_state    = tstq_pkg::S_INSERT;
                        end
                        tstq_pkg::CMD_REMOVE: begin
                            w_ctl.mode = tstq_pkg::CM_DROP;
                        end
                        tstq_pkg::CMD_PERFORM: begin
                            if (w_due[0]) begin
                                w_ctl.mode = tstq_pkg::CM_POP;
                                n_strobe   = 1'b1;
                                n_task     = w_id[0];
                                n_last     = !w_due[1];
                                if (w_due[1]) begin
                                    n_state = tstq_pkg::S_POP;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tstq_pkg::S_INSERT: begin
                w_ctl.mode = tstq_pkg::CM_INSERT;
                n_state    = tstq_pkg::S_IDLE;
            end
            tstq_pkg::S_POP: begin
                // Head is known due; advance and check the next one.
                w_ctl.mode = tstq_pkg::CM_POP;
                n_strobe   = 1'b1;
                n_task     = w_id[0];
                n_last     = !w_due[1];
                if (!w_due[1]) begin
                    n_state = tstq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tstq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tstq_pkg::S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    // Hold the command key for the follow-up cycles.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key_id   <= i_task_id;
            r_key_time <= w_in_time;
        end
        r_task <= n_task;
        r_last <= n_last;
    end

    assign o_valid        = r_strobe;
    assign o_expired_task = r_task;
    assign o_last         = r_last;

    // Occupied cells always form one run from the front.
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (((w_valid >> 1) & ~w_valid) == '0))
        else $error("queue cells not contiguous");

    // The final result of a perform ends the pop sequence.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (r_state == tstq_pkg::S_IDLE))
        else $error("pop sequence continues after last result");

    // A result that is not last is always followed by another result.
    a_not_last_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> o_valid)
        else $error("perform stopped without a last result");

    // The insert step is always followed by idle in the next cycle.
    a_insert_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tstq_pkg::S_INSERT) |=> (r_state == tstq_pkg::S_IDLE))
        else $error("insert step did not return to idle");

endmodule
